// ===== design/spt_pkg.sv =====
package spt_pkg;

  // CORDIC length, capped at the depth of the arctangent table
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 30;
  localparam int NUM_ITER      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  // Q3.28 angle constants
  localparam logic signed [31:0] PI_Q      = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q  = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;

  // 1/K in Q1.30
  localparam logic signed [31:0] INV_GAIN  = 32'sd652032874;

  // rounding bias for Q16.30 -> Q16.16
  localparam logic signed [47:0] RND_BIAS  = 48'sd8192;

  // configuration register indexes
  localparam logic [1:0] REG_FORWARD  = 2'd0;
  localparam logic [1:0] REG_LATERAL  = 2'd1;
  localparam logic [1:0] REG_VERTICAL = 2'd2;

  // stream widths
  localparam int TDATA_W = 192;

  // fields that ride alongside the CORDIC
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] sz;
    logic signed [30:0] hd;
    logic [63:0]        stamp;
  } side_t;

  // atan(2^-i) in Q3.28
  function automatic logic signed [31:0] atan_q(input int i);
    logic signed [31:0] r;
    case (i)
      0:  r = 32'sd210828714;
      1:  r = 32'sd124459457;
      2:  r = 32'sd65760959;
      3:  r = 32'sd33381290;
      4:  r = 32'sd16755422;
      5:  r = 32'sd8385879;
      6:  r = 32'sd4193963;
      7:  r = 32'sd2097109;
      8:  r = 32'sd1048571;
      9:  r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      24: r = 32'sd16;
      25: r = 32'sd8;
      26: r = 32'sd4;
      27: r = 32'sd2;
      28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // clamp a 35-bit sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/sensor_pose_transform_top.sv =====
// Sensor pose transform. Each input transfer carries one platform pose (x, y, z in
// signed Q16.16 m, yaw in signed Q3.28 rad, a 64-bit timestamp) and yields exactly one
// output transfer with the world pose of a sensor mounted at the configured forward,
// lateral and vertical offsets. The offset vector is rotated by yaw with a 16-iteration
// CORDIC (one pipeline stage per iteration), positions saturate to signed 32 bits, yaw
// comes out wrapped into [-pi, pi] and the timestamp passes through. The pipeline
// accepts one pose per clock unless the output stalls. Stages: yaw wrap and offset
// prescale multiply, quadrant fold, one per CORDIC iteration, and a round/add/saturate
// stage that is the output register. A stall on the output holds the whole pipeline,
// so in_tready follows out_tready while a result waits. Offsets must be written
// through cfg_* only while the block is empty; the block does not enforce this.
module sensor_pose_transform_top
  import spt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  // [31:0] platform_x, [63:32] platform_y, [95:64] platform_z,
  // [127:96] platform_heading, [191:128] stamp_in
  input  logic [TDATA_W-1:0] in_tdata,
  // output stream
  output logic               out_tvalid,
  input  logic               out_tready,
  // [31:0] sensor_x, [63:32] sensor_y, [95:64] sensor_z,
  // [126:96] sensor_heading, [190:127] stamp_out, [191] zero
  output logic [TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int N     = NUM_ITER;
  localparam int DEPTH = N + 3;

  // offset registers
  logic signed [31:0] fwd_r, lat_r, vert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      lat_r  <= '0;
      vert_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FORWARD:  fwd_r  <= cfg_data;
        REG_LATERAL:  lat_r  <= cfg_data;
        REG_VERTICAL: vert_r <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // global advance: every stage moves when the output slot is free or being drained
  logic en;
  logic [DEPTH-1:0] v_r;

  assign en        = !v_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_tvalid};
    end
  end

  // ---------------- stage 0: yaw wrap, z sum, offset prescale ----------------
  logic signed [31:0] yaw_in, yaw_w;
  logic signed [31:0] pz_in;
  side_t              side0_nxt;

  assign yaw_in = in_tdata[127:96];
  assign pz_in  = in_tdata[95:64];

  // one correction is enough: |yaw| < 2^31 keeps yaw -/+ 2*pi inside [-pi, pi]
  always_comb begin
    if (yaw_in > PI_Q) begin
      yaw_w = yaw_in - TWO_PI_Q;
    end else if (yaw_in < -PI_Q) begin
      yaw_w = yaw_in + TWO_PI_Q;
    end else begin
      yaw_w = yaw_in;
    end
    side0_nxt.px    = in_tdata[31:0];
    side0_nxt.py    = in_tdata[63:32];
    side0_nxt.sz    = sat32(35'(pz_in) + 35'(vert_r));
    side0_nxt.hd    = yaw_w[30:0];
    side0_nxt.stamp = in_tdata[191:128];
  end

  // sideband for stages 0 .. N+1
  side_t              side_r [0:N+1];
  logic signed [63:0] prod_f_r, prod_l_r;   // offset * 1/K, Q16.46

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side0_nxt;
      prod_f_r  <= 64'(fwd_r) * 64'(INV_GAIN);
      prod_l_r  <= 64'(lat_r) * 64'(INV_GAIN);
    end
  end

  // ---------------- stage 1: quadrant fold into [-pi/2, pi/2] ----------------
  logic signed [47:0] x_r [0:N];   // Q16.30
  logic signed [47:0] y_r [0:N];
  logic signed [31:0] a_r [0:N];   // residual angle, Q3.28

  logic signed [47:0] x0, y0, x_fold_nxt, y_fold_nxt;
  logic signed [31:0] a0, a_fold_nxt;

  always_comb begin
    x0 = prod_f_r[63:16];   // floor shift by 16
    y0 = prod_l_r[63:16];
    a0 = 32'(side_r[0].hd);
    if (a0 > HALF_PI_Q) begin
      a_fold_nxt = a0 - PI_Q;
      x_fold_nxt = -x0;
      y_fold_nxt = -y0;
    end else if (a0 < -HALF_PI_Q) begin
      a_fold_nxt = a0 + PI_Q;
      x_fold_nxt = -x0;
      y_fold_nxt = -y0;
    end else begin
      a_fold_nxt = a0;
      x_fold_nxt = x0;
      y_fold_nxt = y0;
    end
  end

  // ---------------- CORDIC stages: one micro-rotation each ----------------
  logic signed [47:0] x_nxt [0:N-1];
  logic signed [47:0] y_nxt [0:N-1];
  logic signed [31:0] a_nxt [0:N-1];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (!a_r[k][31]) begin
        x_nxt[k] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k] = y_r[k] + (x_r[k] >>> k);
        a_nxt[k] = a_r[k] - atan_q(k);
      end else begin
        x_nxt[k] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k] = y_r[k] - (x_r[k] >>> k);
        a_nxt[k] = a_r[k] + atan_q(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_fold_nxt;
      y_r[0]    <= y_fold_nxt;
      a_r[0]    <= a_fold_nxt;
      side_r[1] <= side_r[0];
      for (int k = 0; k < N; k++) begin
        x_r[k+1]    <= x_nxt[k];
        y_r[k+1]    <= y_nxt[k];
        a_r[k+1]    <= a_nxt[k];
        side_r[k+2] <= side_r[k+1];
      end
    end
  end

  // ---------------- output stage: round half up, add, saturate ----------------
  logic signed [47:0] xr_b, yr_b;
  logic signed [33:0] rx, ry;
  logic signed [31:0] sx_nxt, sy_nxt;
  logic signed [31:0] sx_r, sy_r, sz_r;
  logic signed [30:0] hd_r;
  logic [63:0]        stamp_r;

  // the residual angle of the last stage is not needed
  always_comb begin
    xr_b   = x_r[N] + RND_BIAS;
    yr_b   = y_r[N] + RND_BIAS;
    rx     = xr_b[47:14];
    ry     = yr_b[47:14];
    sx_nxt = sat32(35'(side_r[N+1].px) + 35'(rx));
    sy_nxt = sat32(35'(side_r[N+1].py) + 35'(ry));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sz_r    <= side_r[N+1].sz;
      hd_r    <= side_r[N+1].hd;
      stamp_r <= side_r[N+1].stamp;
    end
  end

  assign out_tvalid = v_r[DEPTH-1];
  assign out_tdata  = {1'b0, stamp_r, hd_r, sz_r, sy_r, sx_r};

endmodule

// ===== design/spt_chk.sv =====
module spt_chk
  import spt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // pipeline is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input side stalls only while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output slot");

  // wrapped heading stays within [-pi, pi]
  a_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[126:96]) <= $signed(PI_Q[30:0]))
                && ($signed(out_tdata[126:96]) >= -$signed(PI_Q[30:0])))
    else $error("heading out of range");

  // pad bit is zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[191])
    else $error("tdata pad bit set");

endmodule

bind sensor_pose_transform_top spt_chk u_spt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb.sv =====
module tb
  import spt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // unused register index, writes to it must have no effect
  localparam logic [1:0] REG_SPARE = 2'd3;

  // wrap, fold, CORDIC_STAGES iterations, round/add/saturate
  localparam int LATENCY = 19;
  // watchdog limit, a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 500000;
  localparam int ROT_STAGES = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_CYCLES = 400;

  // atan(2^-i) in Q3.28, round to nearest
  localparam longint ARCTAN_Q [0:29] = '{
    210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287,
    262144, 131072, 65536, 32768, 16384,
    8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16,
    8, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [30:0] hd;
    logic [63:0]        stamp;
  } pose_result_t;

  // directed rows: register write, pose checked by the predictor, pose with a typed result
  typedef enum logic [1:0] {ROW_CFG, ROW_POSE, ROW_POSE_TYPED} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [1:0]   idx;
    logic [31:0]  cfg_val;
    logic [191:0] pose;
    pose_result_t want;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_wr_en  = 1'b0;
  logic [1:0]         cfg_index  = '0;
  logic [31:0]        cfg_data   = '0;

  // testbench copy of the offset registers
  logic signed [31:0] fwd_off  = '0;
  logic signed [31:0] lat_off  = '0;
  logic signed [31:0] vert_off = '0;

  pose_result_t sensor_pose_q[$];
  stim_row_t    stim_rows[$];
  int           mismatch_cnt = 0;
  int           cycle_cnt    = 0;
  bit           gaps_on      = 1'b1;
  bit           hold_off_req = 1'b0;

  sensor_pose_transform_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    // [31:0] x, [63:32] y, [95:64] z, [127:96] heading, [191:128] stamp
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [31:0] x, [63:32] y, [95:64] z, [126:96] heading, [190:127] stamp, [191] zero
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // world pose of the sensor for one platform pose under the current offsets
  function automatic pose_result_t predict_sensor_pose(input logic [191:0] d);
    longint       px, py, pz, yaw, ang, cx, cy, nx, ny;
    pose_result_t r;
    px  = longint'($signed(d[31:0]));
    py  = longint'($signed(d[63:32]));
    pz  = longint'($signed(d[95:64]));
    yaw = longint'($signed(d[127:96]));
    while (yaw > PI_Q) yaw -= TWO_PI_Q;
    while (yaw < -PI_Q) yaw += TWO_PI_Q;
    // offsets to Q16.30, pre-divided by the CORDIC gain
    cx = (longint'(fwd_off) * longint'(INV_GAIN)) >>> 16;
    cy = (longint'(lat_off) * longint'(INV_GAIN)) >>> 16;
    // fold the angle into [-pi/2, pi/2], negating the vector
    ang = yaw;
    if (ang > HALF_PI_Q) begin
      ang -= PI_Q;
      cx = -cx;
      cy = -cy;
    end else if (ang < -HALF_PI_Q) begin
      ang += PI_Q;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < ROT_STAGES; i++) begin
      if (ang >= 0) begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        ang -= ARCTAN_Q[i];
      end else begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        ang += ARCTAN_Q[i];
      end
      cx = nx;
      cy = ny;
    end
    r.sx    = clamp32(px + ((cx + 8192) >>> 14));
    r.sy    = clamp32(py + ((cy + 8192) >>> 14));
    r.sz    = clamp32(pz + longint'(vert_off));
    r.hd    = yaw[30:0];
    r.stamp = d[191:128];
    return r;
  endfunction

  function automatic logic [191:0] pack_pose(input logic [31:0] x, y, z, h,
                                             input logic [63:0] stamp);
    return {stamp, h, z, y, x};
  endfunction

  // idle length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
      1: return 32'h8000_0000 + $urandom_range(0, 1 << 20);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_heading();
    int          r;
    logic [31:0] jit;
    r   = $urandom_range(0, 19);
    jit = $urandom_range(0, 8) - 4;
    case (r)
      0: return PI_Q + jit;
      1: return -PI_Q + jit;
      2: return HALF_PI_Q + jit;
      3: return -HALF_PI_Q + jit;
      4: return jit;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 32'h7FFF_FFFF;
    if (r < 6) return 32'h8000_0000;
    if (r < 8) return 32'h0;
    if (r < 14) return $urandom_range(0, 1 << 23) - (1 << 22);
    return $urandom;
  endfunction

  task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.idx     = idx;
    row.cfg_val = val;
    stim_rows.push_back(row);
  endtask

  task automatic add_pose(input logic [31:0] x, y, z, h, input logic [63:0] stamp);
    stim_row_t row;
    row.kind = ROW_POSE;
    row.pose = pack_pose(x, y, z, h, stamp);
    stim_rows.push_back(row);
  endtask

  // zero offsets: position passes straight through, only the wrapped heading is typed
  task automatic add_typed(input logic [31:0] x, y, z, h, input logic [63:0] stamp,
                           input logic signed [30:0] want_hd);
    stim_row_t row;
    row.kind       = ROW_POSE_TYPED;
    row.pose       = pack_pose(x, y, z, h, stamp);
    row.want.sx    = x;
    row.want.sy    = y;
    row.want.sz    = z;
    row.want.hd    = want_hd;
    row.want.stamp = stamp;
    stim_rows.push_back(row);
  endtask

  // offer one pose, hold it until the transfer, then maybe idle;
  // tvalid stays high when no idle follows so back-to-back calls stream
  task automatic offer_pose(input logic [191:0] d, input pose_result_t want);
    int gap;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sensor_pose_q.push_back(want);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every pending result
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sensor_pose_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FORWARD:  fwd_off  = val;
      REG_LATERAL:  lat_off  = val;
      REG_VERTICAL: vert_off = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [63:0] want, got);
    if (want !== got) begin
      if (mismatch_cnt < 10)
        $display("mismatch %s: expected %h, got %h", fname, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic take_result();
    pose_result_t got, want;
    got.sx    = out_tdata[31:0];
    got.sy    = out_tdata[63:32];
    got.sz    = out_tdata[95:64];
    got.hd    = out_tdata[126:96];
    got.stamp = out_tdata[190:127];
    if (sensor_pose_q.size() == 0) begin
      if (mismatch_cnt < 10)
        $display("output transfer with nothing pending: %h", out_tdata);
      mismatch_cnt++;
    end else begin
      want = sensor_pose_q.pop_front();
      check_field("sensor_x", want.sx, got.sx);
      check_field("sensor_y", want.sy, got.sy);
      check_field("sensor_z", want.sz, got.sz);
      check_field("sensor_heading", want.hd, got.hd);
      check_field("stamp_out", want.stamp, got.stamp);
    end
  endtask

  // result side: check each output transfer, drive tready with random stalls;
  // a hold-off request parks tready low for HOLD_CYCLES to back up the pipeline
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) take_result();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    pose_result_t want;
    logic [191:0] d;

    // directed rows; offsets are zero out of reset and the spare index must not move them
    add_cfg(REG_SPARE, 32'h7FFF_FFFF);
    add_typed(32'h0, 32'h0, 32'h0, 32'h0, 64'h0, 31'sd0);
    add_typed(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 31'sd460853934);
    add_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              64'h8000_0000_0000_0001, -31'sd460853935);
    add_typed(32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, PI_Q,
              64'h5555_5555_AAAA_AAAA, 31'sd843314857);
    add_typed(32'h1234_5678, 32'h8765_4321, 32'hAAAA_AAAA, PI_Q + 1,
              64'hAAAA_AAAA_5555_5555, -31'sd843314855);
    add_typed(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, -PI_Q,
              64'h0000_0001_0000_0000, -31'sd843314857);
    add_typed(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -PI_Q - 1,
              64'h0123_4567_89AB_CDEF, 31'sd843314855);
    // largest offsets: positive saturation, quadrant fold edges
    add_cfg(REG_FORWARD, 32'h7FFF_FFFF);
    add_cfg(REG_LATERAL, 32'h7FFF_FFFF);
    add_cfg(REG_VERTICAL, 32'h7FFF_FFFF);
    add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 64'h1);
    add_pose(32'h0, 32'h0, 32'h0, HALF_PI_Q, 64'h2);
    add_pose(32'h0, 32'h0, 32'h8000_0000, HALF_PI_Q + 1, 64'h3);
    add_pose(32'h8000_0000, 32'h8000_0000, 32'h0, -HALF_PI_Q - 1, 64'h4);
    // most negative offsets: negative saturation
    add_cfg(REG_FORWARD, 32'h8000_0000);
    add_cfg(REG_LATERAL, 32'h8000_0000);
    add_cfg(REG_VERTICAL, 32'h8000_0000);
    add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 64'h5);
    add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, PI_Q, 64'h6);
    add_pose(32'h0, 32'h0, 32'h0, -HALF_PI_Q, 64'h7);
    // one meter ahead, swept through the quadrants
    add_cfg(REG_FORWARD, 32'h0001_0000);
    add_cfg(REG_LATERAL, 32'h0);
    add_cfg(REG_VERTICAL, 32'h0);
    add_pose(32'h0, 32'h0, 32'h0, 32'h0, 64'h8);
    add_pose(32'h0, 32'h0, 32'h0, HALF_PI_Q, 64'h9);
    add_pose(32'h0, 32'h0, 32'h0, HALF_PI_Q + 1, 64'hA);
    add_pose(32'h0, 32'h0, 32'h0, -HALF_PI_Q, 64'hB);
    add_pose(32'h0, 32'h0, 32'h0, -HALF_PI_Q - 1, 64'hC);
    add_pose(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 64'hD);

    // synchronous reset, once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (stim_rows[k]) begin
      case (stim_rows[k].kind)
        ROW_CFG: begin
          settle();
          write_reg(stim_rows[k].idx, stim_rows[k].cfg_val);
        end
        ROW_POSE: begin
          offer_pose(stim_rows[k].pose, predict_sensor_pose(stim_rows[k].pose));
        end
        default: begin
          offer_pose(stim_rows[k].pose, stim_rows[k].want);
        end
      endcase
    end

    // random phases, new offsets at each idle boundary
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      write_reg(REG_FORWARD, pick_offset());
      write_reg(REG_LATERAL, pick_offset());
      write_reg(REG_VERTICAL, pick_offset());
      if ($urandom_range(0, 1)) write_reg(REG_SPARE, $urandom);
      // phase 2: long receiver hold-off while the sender streams into it;
      // phase 5: no idling on either side
      gaps_on = (ph != 2) && (ph != 5);
      if (ph == 2) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // phase 4: sender pauses mid-stream until the pipeline drains
        if (ph == 4 && n == PHASE_ITEMS / 2) settle();
        d = pack_pose(pick_coord(), pick_coord(), pick_coord(), pick_heading(),
                      {$urandom, $urandom});
        want = predict_sensor_pose(d);
        offer_pose(d, want);
      end
    end

    settle();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && sensor_pose_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
